// ----- hw/rtl/ecal_pkg.sv -----
// Shared types, constants and calendar helper functions for the epoch-to-calendar converter.
package ecal_pkg;

  // Width of the shared subtract/compare datapath.
  localparam int unsigned AluW = 32;

  // Fixed calendar constants.
  localparam logic [AluW-1:0] SecsPerDay  = 32'd86400;
  localparam logic [AluW-1:0] SecsPerMin  = 32'd60;
  localparam logic [AluW-1:0] DaysPerWeek = 32'd7;
  localparam logic [AluW-1:0] DaysCommon  = 32'd365;
  localparam logic [AluW-1:0] DaysLeap    = 32'd366;
  localparam logic [10:0]     FirstYear   = 11'd1970;
  // 1970-01-01 was a Thursday.
  localparam logic [15:0]     EpochWeekday = 16'd4;

  // Register map.
  localparam logic REG_ZONE = 1'b0;

  // Result of one pass through the shared unit.
  typedef struct packed {
    logic            ge;
    logic [AluW-1:0] diff;
  } alu_res_t;

  // One converted request.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  month_day;
    logic [3:0]  month;
    logic [10:0] year;
  } ecal_res_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // Gregorian leap test. Local time never leaves 1970..2038, where the only
  // century year is 2000, a leap year; the nearest common century year that
  // an 11-bit year can hold is 1900.
  function automatic logic is_leap(input logic [10:0] y);
    logic four;
    logic century_common;
    begin
      four           = (y[1:0] == 2'b00);
      century_common = (y == 11'd1900);
      return four && !century_common;
    end
  endfunction

  // Days in the year before the first day of month index m (0 = January).
  function automatic logic [AluW-1:0] cum_days(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd334;
      endcase
      // Months after February gain a day in a leap year.
      if (leap && (m >= 4'd2)) begin
        base = base + 9'd1;
      end
      return AluW'(base);
    end
  endfunction

endpackage

// ----- hw/rtl/ecal_alu.sv -----
// Shared subtract-and-compare unit used for every division step and table search.
module ecal_alu
  import ecal_pkg::*;
(
  input  logic [AluW-1:0] a,
  input  logic [AluW-1:0] b,
  output alu_res_t        res
);

  logic [AluW:0] wide;

  // One wide subtraction; the borrow tells whether a >= b.
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[AluW];
  assign res.diff = wide[AluW-1:0];

endmodule

// ----- hw/rtl/ecal_seq.sv -----
// Sequencer that drives the shared unit through the divisions, year walk and month search.
module ecal_seq
  import ecal_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AluW-1:0] local_secs,
  input  logic            take,
  output seq_stat_t       stat,
  output ecal_res_t       res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DAY   = 3'd1;
  localparam logic [2:0] S_MIN   = 3'd2;
  localparam logic [2:0] S_HOUR  = 3'd3;
  localparam logic [2:0] S_WEEK  = 3'd4;
  localparam logic [2:0] S_YEAR  = 3'd5;
  localparam logic [2:0] S_MONTH = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]      state;
  logic [3:0]      cnt;
  logic [AluW-1:0] acc;
  logic [15:0]     quo;
  logic [15:0]     days;
  logic [10:0]     year;
  logic [3:0]      mon_idx;
  logic [5:0]      sec_w;
  logic [5:0]      min_w;
  logic [4:0]      hour_w;
  logic [2:0]      wday_w;
  logic [4:0]      mday_w;
  logic [3:0]      mon_w;

  logic [AluW-1:0] op_b;
  alu_res_t        alu;
  logic [AluW-1:0] acc_step;
  logic [15:0]     quo_next;
  logic            leap;

  assign leap = is_leap(year);

  // Divisor or table operand for the current step.
  always_comb begin
    unique case (state)
      S_DAY:   op_b = SecsPerDay << cnt;
      S_MIN:   op_b = SecsPerMin << cnt;
      S_HOUR:  op_b = SecsPerMin << cnt;
      S_WEEK:  op_b = DaysPerWeek << cnt;
      S_YEAR:  op_b = leap ? DaysLeap : DaysCommon;
      S_MONTH: op_b = cum_days(leap, mon_idx);
      default: op_b = '0;
    endcase
  end

  ecal_alu u_alu (
    .a   (acc),
    .b   (op_b),
    .res (alu)
  );

  // Restoring division step: keep the difference when it did not borrow.
  assign acc_step = alu.ge ? alu.diff : acc;
  assign quo_next = {quo[14:0], alu.ge};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (start) state <= S_DAY;
        S_DAY:   if (cnt == 4'd0) state <= S_MIN;
        S_MIN:   if (cnt == 4'd0) state <= S_HOUR;
        S_HOUR:  if (cnt == 4'd0) state <= S_WEEK;
        S_WEEK:  if (cnt == 4'd0) state <= S_YEAR;
        S_YEAR:  if (!alu.ge) state <= S_MONTH;
        S_MONTH: if (alu.ge) state <= S_DONE;
        S_DONE:  if (take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        acc <= local_secs;
        cnt <= 4'd15;
      end
      S_DAY: begin
        acc <= acc_step;
        quo <= quo_next;
        cnt <= cnt - 4'd1;
        // Day count done; the remainder is seconds of the day.
        if (cnt == 4'd0) begin
          days <= quo_next;
          cnt  <= 4'd10;
        end
      end
      S_MIN: begin
        acc <= acc_step;
        quo <= quo_next;
        cnt <= cnt - 4'd1;
        // Seconds fall out; continue with total minutes of the day.
        if (cnt == 4'd0) begin
          sec_w <= acc_step[5:0];
          acc   <= AluW'(quo_next[10:0]);
          cnt   <= 4'd4;
        end
      end
      S_HOUR: begin
        acc <= acc_step;
        quo <= quo_next;
        cnt <= cnt - 4'd1;
        // Minutes and hours fall out; set up the weekday remainder.
        if (cnt == 4'd0) begin
          min_w  <= acc_step[5:0];
          hour_w <= quo_next[4:0];
          acc    <= AluW'(days + EpochWeekday);
          cnt    <= 4'd13;
        end
      end
      S_WEEK: begin
        acc <= acc_step;
        quo <= quo_next;
        cnt <= cnt - 4'd1;
        // Weekday is the remainder by seven; start the year walk.
        if (cnt == 4'd0) begin
          wday_w <= acc_step[2:0];
          acc    <= AluW'(days);
          year   <= FirstYear;
        end
      end
      S_YEAR: begin
        // Take off whole years while they fit.
        if (alu.ge) begin
          acc  <= alu.diff;
          year <= year + 11'd1;
        end else begin
          mon_idx <= 4'd11;
        end
      end
      S_MONTH: begin
        // Search down for the last month that starts on or before this day.
        if (alu.ge) begin
          mday_w <= alu.diff[4:0] + 5'd1;
          mon_w  <= mon_idx + 4'd1;
        end else begin
          mon_idx <= mon_idx - 4'd1;
        end
      end
      S_DONE: begin
        acc <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  assign res.second    = sec_w;
  assign res.minute    = min_w;
  assign res.hour      = hour_w;
  assign res.weekday   = wday_w;
  assign res.month_day = mday_w;
  assign res.month     = mon_w;
  assign res.year      = year;

endmodule

// ----- hw/rtl/epoch_seconds_to_calendar.sv -----
// Top level: converts seconds since 1970 UTC into local calendar date and time.
//
//   Channel   Signals                            Direction  Contents
//   input     in_valid / in_stall                in         epoch_seconds
//   output    out_valid / out_stall              out        second .. year
//   config    psel penable pwrite paddr pwdata   in/out     zone_minutes_west
//
// Each request runs through the restoring divisions, a walk over Y (0..68) whole years
// from 1970 and M (1..12) month table compares, all done by the single shared
// subtract/compare unit in ecal_seq, which handles one step per cycle.
// Reset is synchronous and clears the zone register to zero and the control state.
// A new request is taken only while the sequencer is idle; a finished result waits in
// the output register under out_stall while the next request is already being worked.
module epoch_seconds_to_calendar
  import ecal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] epoch_seconds,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [4:0]  month_day,
  output logic [3:0]  month,
  output logic [10:0] year,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [11:0] zone;
  logic signed [17:0] zone_prod;
  logic signed [33:0] local_s;
  logic [AluW-1:0]    local_u;
  logic               in_acc;
  logic               load;
  seq_stat_t          stat;
  ecal_res_t          res;

  // Configuration register, written on the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ZONE)) begin
      zone <= pwdata[11:0];
    end
  end

  assign prdata = (paddr[2] == REG_ZONE) ? 32'(zone) : 32'd0;

  // Shift into local time and clamp anything before the epoch to zero.
  assign zone_prod = 18'(zone) * 18'sd60;
  assign local_s   = $signed({3'b000, epoch_seconds}) - 34'(zone_prod);
  assign local_u   = local_s[33] ? '0 : local_s[31:0];

  assign in_stall = ~stat.idle;
  assign in_acc   = in_valid && stat.idle;

  // The result moves to the output register once that register is free.
  assign load = stat.done && (!out_valid || !out_stall);

  ecal_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_acc),
    .local_secs (local_u),
    .take       (load),
    .stat       (stat),
    .res        (res)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      second    <= res.second;
      minute    <= res.minute;
      hour      <= res.hour;
      weekday   <= res.weekday;
      month_day <= res.month_day;
      month     <= res.month;
      year      <= res.year;
    end
  end

endmodule

// ----- hw/rtl/ecal_checker.sv -----
// Port-level checker for the epoch-to-calendar converter, bound to the top level.
module ecal_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  second,
  input logic [5:0]  minute,
  input logic [4:0]  hour,
  input logic [2:0]  weekday,
  input logic [4:0]  month_day,
  input logic [3:0]  month,
  input logic [10:0] year,
  input logic        pready
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
      && $stable(month_day) && $stable(second))
    else $error("stalled result changed");

  // An accepted request makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after a request");

  // Every delivered result is a valid calendar date and time.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
      && (weekday < 3'd7) && (month_day != 5'd0) && (month != 4'd0)
      && (month < 4'd13) && (year >= 11'd1970) && (year <= 11'd2038))
    else $error("result out of calendar range");

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall && pready)
    else $error("block not idle after reset");

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (.*);
